// ===== rtl/strict_utf8_to_utf16_decoder_top_macros.svh =====
// ----------------------------------------------------------------------------
// strict_utf8_to_utf16_decoder_top_macros
// Assertion shorthands shared by the queue and back modules. Each expects clk and
// rst_n in scope.
// ----------------------------------------------------------------------------
`ifndef STRICT_UTF8_TO_UTF16_DECODER_TOP_MACROS_SVH
`define STRICT_UTF8_TO_UTF16_DECODER_TOP_MACROS_SVH

// same-cycle implication
`define U8U16D_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define U8U16D_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/u8u16d_pkg.sv =====
// ----------------------------------------------------------------------------
// u8u16d_pkg
// Types and constants of the strict UTF-8 to UTF-16 line decoder.
// ----------------------------------------------------------------------------
package u8u16d_pkg;

  localparam int BYTE_W  = 8;
  localparam int UNIT_W  = 16;
  localparam int POINT_W = 21;

  localparam logic [7:0] LEAD2_LO = 8'hC2;
  localparam logic [7:0] LEAD2_HI = 8'hDF;
  localparam logic [7:0] LEAD3_LO = 8'hE0;
  localparam logic [7:0] LEAD3_HI = 8'hEF;
  localparam logic [7:0] LEAD4_LO = 8'hF0;
  localparam logic [7:0] LEAD4_HI = 8'hF4;

  localparam logic [1:0] CONT_TAG = 2'b10;

  localparam logic [POINT_W-1:0] MIN_LEN1  = 21'h00080;
  localparam logic [POINT_W-1:0] MIN_LEN2  = 21'h00800;
  localparam logic [POINT_W-1:0] MIN_LEN3  = 21'h10000;
  localparam logic [POINT_W-1:0] MAX_POINT = 21'h10FFFF;
  localparam logic [POINT_W-1:0] SURR_LO   = 21'h0D800;
  localparam logic [POINT_W-1:0] SURR_HI   = 21'h0DFFF;
  localparam logic [POINT_W-1:0] BMP_MAX   = 21'h0FFFF;

  localparam logic [UNIT_W-1:0] HIGH_BASE = 16'hD800;
  localparam logic [UNIT_W-1:0] LOW_BASE  = 16'hDC00;

  localparam logic STATUS_OK  = 1'b0;
  localparam logic STATUS_REJ = 1'b1;

  // one queued result group: a single unit or a surrogate pair
  typedef struct packed {
    logic [UNIT_W-1:0] unit0;
    logic [UNIT_W-1:0] unit1;
    logic              pair;
    logic              status;
    logic              line_end;
  } entry_t;

endpackage

// ===== rtl/u8u16d_byte_if.sv =====
// ----------------------------------------------------------------------------
// u8u16d_byte_if
// Byte channel: one UTF-8 byte and its end-of-line flag per transfer.
// ----------------------------------------------------------------------------
interface u8u16d_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       end_of_line;

  modport source (output valid, output in_byte, output end_of_line, input ready);
  modport sink   (input valid, input in_byte, input end_of_line, output ready);
endinterface

// ===== rtl/u8u16d_unit_if.sv =====
// ----------------------------------------------------------------------------
// u8u16d_unit_if
// Result channel: one UTF-16 code unit with status and line end per transfer.
// ----------------------------------------------------------------------------
interface u8u16d_unit_if;
  logic        valid;
  logic        ready;
  logic [15:0] code_unit;
  logic        status;
  logic        line_end;

  modport source (output valid, output code_unit, output status, output line_end,
                  input ready);
  modport sink   (input valid, input code_unit, input status, input line_end,
                  output ready);
endinterface

// ===== rtl/u8u16d_front.sv =====
// ----------------------------------------------------------------------------
// u8u16d_front
// Accepts bytes, tracks the sequence state and builds result groups.
// ----------------------------------------------------------------------------
module u8u16d_front (
  input  logic                clk,
  input  logic                rst_n,
  u8u16d_byte_if.sink         in_bus,
  output logic                push_valid,
  input  logic                push_ready,
  output u8u16d_pkg::entry_t  push_data
);
  import u8u16d_pkg::*;

  logic [1:0]         rem_r, rem_nxt;
  logic [1:0]         len_r, len_nxt;
  logic [POINT_W-1:0] pp_r, pp_nxt;
  logic               failed_r, failed_nxt;

  logic [7:0]         b;
  logic               eol;
  logic               accept;
  logic [POINT_W-1:0] cp;
  logic [POINT_W-1:0] minimum;
  logic [POINT_W-1:0] adj;
  logic               cp_bad;
  logic               emit;
  entry_t             ent;

  assign b      = in_bus.in_byte;
  assign eol    = in_bus.end_of_line;
  assign accept = in_bus.valid && in_bus.ready;
  assign in_bus.ready = push_ready;

  assign cp  = {pp_r[POINT_W-7:0], b[5:0]};
  assign adj = cp - MIN_LEN3;

  always_comb begin
    unique case (len_r)
      2'd1:    minimum = MIN_LEN1;
      2'd2:    minimum = MIN_LEN2;
      default: minimum = MIN_LEN3;
    endcase
  end

  assign cp_bad = (cp < minimum) || (cp > MAX_POINT) || (cp >= SURR_LO && cp <= SURR_HI);

  always_comb begin
    rem_nxt    = rem_r;
    len_nxt    = len_r;
    pp_nxt     = pp_r;
    failed_nxt = failed_r;
    emit       = 1'b0;
    ent        = '0;

    if (!failed_r) begin
      if (rem_r == 2'd0) begin
        if (!b[7]) begin
          emit      = 1'b1;
          ent.unit0 = {8'h00, b};
        end else if (b >= LEAD2_LO && b <= LEAD2_HI) begin
          rem_nxt = 2'd1; len_nxt = 2'd1; pp_nxt = {16'h0000, b[4:0]};
        end else if (b >= LEAD3_LO && b <= LEAD3_HI) begin
          rem_nxt = 2'd2; len_nxt = 2'd2; pp_nxt = {17'h00000, b[3:0]};
        end else if (b >= LEAD4_LO && b <= LEAD4_HI) begin
          rem_nxt = 2'd3; len_nxt = 2'd3; pp_nxt = {18'h00000, b[2:0]};
        end else begin
          failed_nxt = 1'b1;
        end
      end else if (b[7:6] != CONT_TAG) begin
        failed_nxt = 1'b1;
      end else begin
        pp_nxt  = cp;
        rem_nxt = rem_r - 2'd1;
        if (rem_r == 2'd1) begin
          if (cp_bad) begin
            failed_nxt = 1'b1;
          end else if (cp > BMP_MAX) begin
            emit      = 1'b1;
            ent.pair  = 1'b1;
            ent.unit0 = HIGH_BASE + {6'b0, adj[19:10]};
            ent.unit1 = LOW_BASE | {6'b0, adj[9:0]};
          end else begin
            emit      = 1'b1;
            ent.unit0 = cp[UNIT_W-1:0];
          end
          len_nxt = 2'd0;
          pp_nxt  = '0;
        end
      end
    end

    // an open sequence at the line end fails the line
    if (eol && !failed_nxt && rem_nxt != 2'd0) begin
      failed_nxt = 1'b1;
    end

    if (failed_nxt) begin
      emit = eol;
      ent  = '0;
      ent.status   = STATUS_REJ;
      ent.line_end = 1'b1;
    end else begin
      ent.status   = STATUS_OK;
      ent.line_end = eol;
    end

    if (eol) begin
      rem_nxt    = 2'd0;
      len_nxt    = 2'd0;
      pp_nxt     = '0;
      failed_nxt = 1'b0;
    end
  end

  assign push_valid = accept && emit;
  assign push_data  = ent;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rem_r    <= 2'd0;
      len_r    <= 2'd0;
      pp_r     <= '0;
      failed_r <= 1'b0;
    end else if (accept) begin
      rem_r    <= rem_nxt;
      len_r    <= len_nxt;
      pp_r     <= pp_nxt;
      failed_r <= failed_nxt;
    end
  end

endmodule

// ===== rtl/u8u16d_queue.sv =====
// ----------------------------------------------------------------------------
// u8u16d_queue
// Short FIFO of result groups between the front and back parts.
// ----------------------------------------------------------------------------
`include "strict_utf8_to_utf16_decoder_top_macros.svh"

module u8u16d_queue #(
  parameter int DEPTH = 4
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push_valid,
  output logic                push_ready,
  input  u8u16d_pkg::entry_t  push_data,
  output logic                head_valid,
  input  logic                pop,
  output u8u16d_pkg::entry_t  head_data
);
  import u8u16d_pkg::*;

  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST = PW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL = CW'(DEPTH);

  entry_t          mem_r [DEPTH];
  logic [PW-1:0]   wr_ptr_r, rd_ptr_r;
  logic [CW-1:0]   count_r;
  logic            do_push, do_pop;

  assign push_ready = (count_r != FULL);
  assign head_valid = (count_r != '0);
  assign head_data  = mem_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop && head_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == LAST) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == LAST) ? '0 : rd_ptr_r + 1'b1;
      end
      case ({do_push, do_pop})
        2'b10:   count_r <= count_r + 1'b1;
        2'b01:   count_r <= count_r - 1'b1;
        default: count_r <= count_r;
      endcase
    end
  end

  `U8U16D_ASSERT_NOW(a_no_push_when_full, push_valid && !push_ready, 1'b0, "push into full queue")
  `U8U16D_ASSERT_NOW(a_count_bound, 1'b1, count_r <= FULL, "queue count out of range")

endmodule

// ===== rtl/u8u16d_back.sv =====
// ----------------------------------------------------------------------------
// u8u16d_back
// Drives queued result groups onto the output channel, one code unit per transfer.
// ----------------------------------------------------------------------------
`include "strict_utf8_to_utf16_decoder_top_macros.svh"

module u8u16d_back (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                head_valid,
  output logic                pop,
  input  u8u16d_pkg::entry_t  head_data,
  u8u16d_unit_if.source       out_bus
);
  import u8u16d_pkg::*;

  logic half_r;
  logic xfer;
  logic last_unit;

  assign last_unit = !head_data.pair || half_r;
  assign xfer      = out_bus.valid && out_bus.ready;
  assign pop       = xfer && last_unit;

  assign out_bus.valid     = head_valid;
  assign out_bus.code_unit = half_r ? head_data.unit1 : head_data.unit0;
  assign out_bus.status    = head_data.status;
  assign out_bus.line_end  = head_data.line_end && last_unit;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      half_r <= 1'b0;
    end else if (xfer) begin
      // advance to the low unit of a pair, drop back after the group
      half_r <= !last_unit;
    end
  end

  `U8U16D_ASSERT_NOW(a_half_needs_pair, half_r, head_valid && head_data.pair, "low half without pair")
  `U8U16D_ASSERT_NEXT(a_pair_advances, xfer && head_data.pair && !half_r, half_r, "pair did not advance")

endmodule

// ===== rtl/strict_utf8_to_utf16_decoder_top.sv =====
// ----------------------------------------------------------------------------
// strict_utf8_to_utf16_decoder_top: strict UTF-8 to UTF-16 line decoder
// Groups pass through the queue register, pair low unit after high unit. One
// byte and one code unit per cycle, out_bus.ready allowing; in_bus.ready drops
// only while QDEPTH-entry queue is full. Sync reset clears all but queue data.
// ----------------------------------------------------------------------------
module strict_utf8_to_utf16_decoder_top #(
  parameter int QDEPTH = 4
) (
  input  logic          clk,
  input  logic          rst_n,
  u8u16d_byte_if.sink   in_bus,
  u8u16d_unit_if.source out_bus
);
  import u8u16d_pkg::*;

  logic   push_valid, push_ready;
  entry_t push_data;
  logic   head_valid, pop;
  entry_t head_data;

  u8u16d_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_bus     (in_bus),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data)
  );

  u8u16d_queue #(
    .DEPTH (QDEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data),
    .head_valid (head_valid),
    .pop        (pop),
    .head_data  (head_data)
  );

  u8u16d_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_valid (head_valid),
    .pop        (pop),
    .head_data  (head_data),
    .out_bus    (out_bus)
  );

endmodule
